// ----- rtl/masked_sprite_row_blitter_macros.svh -----
// Assertion macros for the masked sprite row blitter checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef MASKED_SPRITE_ROW_BLITTER_MACROS_SVH
`define MASKED_SPRITE_ROW_BLITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/msrb_pkg.sv -----
// Shared types and constants for the masked sprite row blitter.
// No dependencies.
package msrb_pkg;

    localparam int unsigned LANES = 4;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_ATTR  = 1'b1
    } op_t;

    localparam logic [7:0] ATTR_TRANSPARENT = 8'h80;
    localparam logic signed [10:0] X_MIN = -11'sd23;

    typedef struct packed
    {
        op_t             op;
        logic [7:0]      row;
        logic [4:0]      cell0;
        logic [31:0]     src;
        logic [31:0]     mask;
        logic [7:0]      attr;
        logic [LANES-1:0] cells;
    } entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ----- rtl/masked_sprite_row_blitter.sv -----
// Masked sprite row blitter, top level. A request's first command passes through the queue
// slot, then the back end's output register. The back end emits one byte command per cycle
// unless the output stalls; a request yields one command per unclipped cell (1 to 4).
// Filtered requests are dropped at the input. A two-entry queue sets how far the front
// runs ahead. Reset clears the queue, output valid and the layer to 0.
module masked_sprite_row_blitter #(
    parameter int SCREEN_CELLS = 32,
    parameter int PIXEL_ROWS   = 192,
    parameter int ATTR_ROWS    = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic              active,
    input  logic [7:0]        sprite_layer,
    input  logic signed [9:0] x_pos,
    input  logic signed [8:0] row_index,
    input  logic [31:0]       pattern_word,
    input  logic [31:0]       mask_word,
    input  logic [7:0]        attr_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              target_buffer,
    output logic [7:0]        out_row,
    output logic [4:0]        out_cell,
    output logic [7:0]        and_mask,
    output logic [7:0]        or_data,
    output logic              last
);
    import msrb_pkg::*;

    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        head;
    queue_status_t q_status;

    msrb_front #(
        .SCREEN_CELLS(SCREEN_CELLS),
        .PIXEL_ROWS  (PIXEL_ROWS),
        .ATTR_ROWS   (ATTR_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .active      (active),
        .sprite_layer(sprite_layer),
        .x_pos       (x_pos),
        .row_index   (row_index),
        .pattern_word(pattern_word),
        .mask_word   (mask_word),
        .attr_value  (attr_value),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    msrb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    msrb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_buffer(target_buffer),
        .out_row      (out_row),
        .out_cell     (out_cell),
        .and_mask     (and_mask),
        .or_data      (or_data),
        .last         (last)
    );

endmodule

// ----- rtl/msrb_front.sv -----
// Front end: holds the render layer register, classifies each request and
// builds a queue entry with shifted data, fill mask and per-cell enables. Uses msrb_pkg.
module msrb_front #(
    parameter int SCREEN_CELLS = 32,
    parameter int PIXEL_ROWS   = 192,
    parameter int ATTR_ROWS    = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic                 active,
    input  logic [7:0]           sprite_layer,
    input  logic signed [9:0]    x_pos,
    input  logic signed [8:0]    row_index,
    input  logic [31:0]          pattern_word,
    input  logic [31:0]          mask_word,
    input  logic [7:0]           attr_value,
    input  msrb_pkg::queue_status_t q_status,
    output logic                 push,
    output msrb_pkg::entry_t     push_entry
);
    import msrb_pkg::*;

    localparam logic signed [10:0] X_MAX     = 11'(SCREEN_CELLS * 8 - 1);
    localparam logic [9:0]         PIX_LIM   = 10'(PIXEL_ROWS);
    localparam logic [9:0]         ATTR_LIM  = 10'(ATTR_ROWS);
    localparam logic [7:0]         CELL_LIM  = 8'(SCREEN_CELLS);

    logic [7:0]          layer_reg;
    logic [7:0]          layer_next;
    logic signed [10:0]  x_ext;
    logic [2:0]          shift;
    logic signed [6:0]   cell0;
    logic [9:0]          row_u;
    logic                row_ok;
    logic                pass;
    logic [31:0]         pat_sw;
    logic [31:0]         msk_sw;
    logic [LANES-1:0]    cellv;
    logic signed [7:0]   cpos [LANES];

    assign cfg_ready  = 1'b1;
    assign layer_next = (cfg_valid && cfg_ready) ? cfg_data : layer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_reg <= 8'd0;
        end
        else
        begin
            layer_reg <= layer_next;
        end
    end

    assign x_ext  = {x_pos[9], x_pos};
    assign shift  = x_pos[2:0];
    assign cell0  = x_pos[9:3];
    assign row_u  = {2'b00, row_index[7:0]};
    assign pat_sw = swap_bytes(pattern_word);
    assign msk_sw = swap_bytes(mask_word);

    always_comb
    begin
        row_ok = !row_index[8] &&
                 ((op == OP_PIXEL) ? (row_u < PIX_LIM) : (row_u < ATTR_LIM));
        pass = active && (sprite_layer == layer_reg) &&
               (x_ext >= X_MIN) && (x_ext <= X_MAX) && row_ok &&
               !((op == OP_ATTR) && ((attr_value & ATTR_TRANSPARENT) != 8'd0));
        for (int k = 0; k < LANES; k++)
        begin
            cpos[k]  = {cell0[6], cell0} + 8'(k);
            cellv[k] = !cpos[k][7] && (cpos[k] < CELL_LIM);
        end
        if (op == OP_ATTR && !shift[2])
        begin
            cellv[LANES-1] = 1'b0;
        end
    end

    always_comb
    begin
        push_entry.op    = op_t'(op);
        push_entry.row   = row_index[7:0];
        push_entry.cell0 = cell0[4:0];
        push_entry.src   = pat_sw >> shift;
        push_entry.mask  = (msk_sw >> shift) | ~(32'hffff_ffff >> shift);
        push_entry.attr  = attr_value;
        push_entry.cells = cellv;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall && pass && (cellv != '0);

endmodule

// ----- rtl/msrb_queue.sv -----
// Two-entry queue between the classifier and the command emitter.
// Uses msrb_pkg.
module msrb_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  msrb_pkg::entry_t          push_entry,
    input  logic                      pop,
    output msrb_pkg::entry_t          head,
    output msrb_pkg::queue_status_t   status
);
    import msrb_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = count_reg[1];
    assign status.empty = (count_reg == 2'd0);

endmodule

// ----- rtl/msrb_back.sv -----
// Back end: walks the enabled cells of the head entry, one byte command per cycle
// while the output is not stalled, into the output register. Uses msrb_pkg.
module msrb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  msrb_pkg::entry_t          head,
    input  msrb_pkg::queue_status_t   q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      target_buffer,
    output logic [7:0]                out_row,
    output logic [4:0]                out_cell,
    output logic [7:0]                and_mask,
    output logic [7:0]                or_data,
    output logic                      last
);
    import msrb_pkg::*;

    logic [LANES-1:0] sent_reg;
    logic [LANES-1:0] sent_next;
    logic [LANES-1:0] remaining;
    logic [LANES-1:0] pick;
    logic [1:0]       lane;
    logic             is_last;
    logic             advance;
    logic             valid_reg;
    logic             valid_next;
    logic             tb_reg;
    logic [7:0]       row_reg;
    logic [4:0]       cell_reg;
    logic [7:0]       and_reg;
    logic [7:0]       or_reg;
    logic             last_reg;

    always_comb
    begin
        remaining = head.cells & ~sent_reg;
        pick      = remaining & (~remaining + LANES'(1));
        lane      = 2'd0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            if (pick[k])
            begin
                lane = 2'(k);
            end
        end
        is_last = (remaining & ~pick) == '0;
        advance = !q_status.empty && (!valid_reg || !out_stall);
        pop     = advance && is_last;
        if (pop)
        begin
            sent_next = '0;
        end
        else if (advance)
        begin
            sent_next = sent_reg | pick;
        end
        else
        begin
            sent_next = sent_reg;
        end
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg  <= sent_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tb_reg   <= head.op;
            row_reg  <= head.row;
            cell_reg <= head.cell0 + 5'(lane);
            last_reg <= is_last;
            if (head.op == OP_PIXEL)
            begin
                and_reg <= head.mask[31 - 8 * lane -: 8];
                or_reg  <= head.src[31 - 8 * lane -: 8];
            end
            else
            begin
                and_reg <= 8'd0;
                or_reg  <= head.attr;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign target_buffer = tb_reg;
    assign out_row       = row_reg;
    assign out_cell      = cell_reg;
    assign and_mask      = and_reg;
    assign or_data       = or_reg;
    assign last          = last_reg;

endmodule

// ----- rtl/msrb_checker.sv -----
// Port-level checker for the masked sprite row blitter, bound to the top.
// Depends on masked_sprite_row_blitter_macros.svh.
`include "masked_sprite_row_blitter_macros.svh"

module msrb_checker #(
    parameter int ATTR_ROWS = 48
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       target_buffer,
    input logic [7:0] out_row,
    input logic [4:0] out_cell,
    input logic [7:0] and_mask,
    input logic [7:0] or_data,
    input logic       last
);
    localparam logic [8:0] ATTR_LIM = 9'(ATTR_ROWS);

    `MSRB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_cell) && $stable(last) && $stable(or_data), "stalled command changed")
    `MSRB_ASSERT_NOW(a_attr_mask, out_valid && target_buffer, and_mask == 8'd0, "attribute write with nonzero mask")
    `MSRB_ASSERT_NOW(a_attr_opaque, out_valid && target_buffer, !or_data[7], "transparent attribute emitted")
    `MSRB_ASSERT_NOW(a_attr_row, out_valid && target_buffer, {1'b0, out_row} < ATTR_LIM, "attribute row out of range")

endmodule

bind masked_sprite_row_blitter msrb_checker #(.ATTR_ROWS(ATTR_ROWS)) u_msrb_checker (.*);

// ----- tb/sv/tb_masked_sprite_row_blitter.sv -----
// Self-checking testbench for masked_sprite_row_blitter: a directed table, then random
// row jobs under varying backpressure, each command checked against a local predictor or typed value.
// Depends on msrb_pkg and the masked_sprite_row_blitter RTL.
module tb_masked_sprite_row_blitter;
    import msrb_pkg::*;

    localparam int SCREEN_CELLS  = 32;
    localparam int PIXEL_ROWS    = 192;
    localparam int ATTR_ROWS     = 48;
    localparam int DIRECTED_ROWS = 25;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_CAP    = 100;

    typedef struct packed
    {
        op_t               op;
        logic              active;
        logic [7:0]        sprite_layer;
        logic signed [9:0] x_pos;
        logic signed [8:0] row_index;
        logic [31:0]       pattern_word;
        logic [31:0]       mask_word;
        logic [7:0]        attr_value;
    } row_job_t;

    typedef struct packed
    {
        op_t        target_buffer;
        logic [7:0] out_row;
        logic [4:0] out_cell;
        logic [7:0] and_mask;
        logic [7:0] or_data;
        logic       last;
    } blit_cmd_t;

    typedef enum logic [1:0]
    {
        CHECK_PREDICT,
        CHECK_SILENT,
        CHECK_SINGLE
    } check_kind_t;

    typedef struct packed
    {
        row_job_t    job;
        check_kind_t kind;
        logic [4:0]  typed_cell;
        logic [7:0]  typed_and;
        logic [7:0]  typed_or;
    } directed_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        cfg_data;
    logic              in_valid;
    logic              in_stall;
    op_t               op;
    logic              active;
    logic [7:0]        sprite_layer;
    logic signed [9:0] x_pos;
    logic signed [8:0] row_index;
    logic [31:0]       pattern_word;
    logic [31:0]       mask_word;
    logic [7:0]        attr_value;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              target_buffer;
    logic [7:0]        out_row;
    logic [4:0]        out_cell;
    logic [7:0]        and_mask;
    logic [7:0]        or_data;
    logic              last;

    blit_cmd_t   pending_cmds[$];
    logic [7:0]  layer_setting = 8'h00;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sender_gap_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_PIXEL, 0, 'h00, 16, 10, 'hA5A5A5A5, 'h0F0F0F0F, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'hFF, 16, 10, 'hA5A5A5A5, 'h0F0F0F0F, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, -24, 10, 'h11111111, 'h22222222, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, 256, 10, 'h11111111, 'h22222222, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, -256, 10, 'h11111111, 'h22222222, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, 511, 10, 'h11111111, 'h22222222, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, 40, -1, 'h33333333, 'h44444444, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, 40, 192, 'h33333333, 'h44444444, 'h00}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 40, 48, 'h0, 'h0, 'h05}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 40, -256, 'h0, 'h0, 'h05}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 40, 12, 'h0, 'h0, 'h80}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 40, 12, 'h0, 'h0, 'hFF}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_ATTR, 0, 'h00, 40, 12, 'h0, 'h0, 'h05}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, -23, 0, 'h0, 'h0, 'h15}, CHECK_SILENT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, -23, 0, 'hFFFFFFFF, 'h0, 'h00}, CHECK_SINGLE, 0, 'h00, 'hFF},
        '{'{OP_PIXEL, 1, 'h00, 255, 191, 'h0, 'h0, 'h00}, CHECK_SINGLE, 31, 'hFE, 'h00},
        '{'{OP_ATTR, 1, 'h00, 252, 47, 'h0, 'h0, 'h7F}, CHECK_SINGLE, 31, 'h00, 'h7F},
        '{'{OP_PIXEL, 1, 'h00, 0, 0, 'h12345678, 'hF0F0F0F0, 'h00}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, 8, 100, 'hFFFFFFFF, 'hFFFFFFFF, 'h00}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, -1, 190, 'h80000001, 'h7FFFFFFE, 'h00}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, -17, 1, 'h00FF00FF, 'h0000FFFF, 'h00}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_PIXEL, 1, 'h00, 229, 63, 'hDEADBEEF, 'h01234567, 'h00}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 0, 0, 'h0, 'h0, 'h00}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 4, 47, 'h0, 'h0, 'h7F}, CHECK_PREDICT, 0, 0, 0},
        '{'{OP_ATTR, 1, 'h00, 3, 10, 'h0, 'h0, 'h55}, CHECK_PREDICT, 0, 0, 0}
    };

    masked_sprite_row_blitter #(
        .SCREEN_CELLS(SCREEN_CELLS),
        .PIXEL_ROWS(PIXEL_ROWS),
        .ATTR_ROWS(ATTR_ROWS)
    ) i_dut (.*);

    always #5 clk = ~clk;

    function automatic int predict_commands(input row_job_t j);
        int          xi;
        int          ri;
        int          cell0;
        int          ncells;
        int          c;
        logic [2:0]  shift;
        logic [31:0] src;
        logic [31:0] msk;
        blit_cmd_t   cmd;
        blit_cmd_t   cmds[$];
        xi = j.x_pos;
        ri = j.row_index;
        if (!j.active || j.sprite_layer != layer_setting)
            return 0;
        if (xi < X_MIN || xi > SCREEN_CELLS * 8 - 1)
            return 0;
        shift = xi[2:0];
        cell0 = xi >>> 3;
        if (j.op == OP_PIXEL)
        begin
            if (ri < 0 || ri >= PIXEL_ROWS)
                return 0;
            src = {<<8{j.pattern_word}};
            src = src >> shift;
            msk = {<<8{j.mask_word}};
            msk = msk >> shift;
            if (shift != 0)
                msk = msk | ~(32'hFFFF_FFFF >> shift);
            ncells = 4;
        end
        else
        begin
            if (ri < 0 || ri >= ATTR_ROWS)
                return 0;
            if ((j.attr_value & ATTR_TRANSPARENT) != 0)
                return 0;
            src = '0;
            msk = '0;
            ncells = (shift > 3) ? 4 : 3;
        end
        for (int k = 0; k < ncells; k++)
        begin
            c = cell0 + k;
            if (c < 0 || c >= SCREEN_CELLS)
                continue;
            cmd.target_buffer = j.op;
            cmd.out_row = ri[7:0];
            cmd.out_cell = c[4:0];
            cmd.and_mask = (j.op == OP_PIXEL) ? msk[31 - 8 * k -: 8] : 8'h00;
            cmd.or_data = (j.op == OP_PIXEL) ? src[31 - 8 * k -: 8] : j.attr_value;
            cmd.last = 1'b0;
            cmds.push_back(cmd);
        end
        if (cmds.size() > 0)
            cmds[cmds.size() - 1].last = 1'b1;
        foreach (cmds[i])
            pending_cmds.push_back(cmds[i]);
        return cmds.size();
    endfunction

    function automatic row_job_t random_job();
        row_job_t    j;
        int unsigned pick;
        j.op = op_t'($urandom_range(1));
        j.active = 1'b1;
        j.sprite_layer = layer_setting;
        j.x_pos = 10'($urandom_range(SCREEN_CELLS * 8 + 22) - 23);
        j.row_index = (j.op == OP_PIXEL) ? 9'($urandom_range(PIXEL_ROWS - 1))
                                         : 9'($urandom_range(ATTR_ROWS - 1));
        j.pattern_word = $urandom;
        j.mask_word = $urandom;
        j.attr_value = 8'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 6)
            j.x_pos = $urandom_range(1) ? 10'($urandom_range(7) - 23)
                                        : 10'($urandom_range(SCREEN_CELLS * 8 - 8,
                                                             SCREEN_CELLS * 8 - 1));
        else if (pick < 10)
            j.active = 1'b0;
        else if (pick < 14)
            j.sprite_layer = 8'($urandom);
        else if (pick < 19)
            j.x_pos = 10'($urandom);
        else if (pick < 24)
            j.row_index = 9'($urandom);
        else if (pick < 28)
            j.attr_value = 8'($urandom);
        return j;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_command();
        blit_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            report_mismatch($sformatf("unexpected command row %0d cell %0d", out_row, out_cell));
            return;
        end
        want = pending_cmds.pop_front();
        check_field("target_buffer", target_buffer, want.target_buffer);
        check_field("out_row", out_row, want.out_row);
        check_field("out_cell", out_cell, want.out_cell);
        check_field("and_mask", and_mask, want.and_mask);
        check_field("or_data", or_data, want.or_data);
        check_field("last", last, want.last);
    endtask

    task automatic send_job(input row_job_t j);
        in_valid <= 1'b1;
        op <= j.op;
        active <= j.active;
        sprite_layer <= j.sprite_layer;
        x_pos <= j.x_pos;
        row_index <= j.row_index;
        pattern_word <= j.pattern_word;
        mask_word <= j.mask_word;
        attr_value <= j.attr_value;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_render_layer(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        layer_setting = value;
    endtask

    task automatic run_phase(input int gap_pct, input int stall_pct, input int jobs,
                             input bit with_pressure);
        int       sent;
        row_job_t j;
        sender_gap_pct = gap_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        if (with_pressure)
            hold_requests <= hold_requests + 1;
        while (sent < jobs)
        begin
            j = random_job();
            send_job(j);
            void'(predict_commands(j));
            sent++;
            if (with_pressure && sent == jobs / 2)
                wait_drained();
            sender_gap();
        end
        wait_drained();
    endtask

    // receiver backpressure: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_command();
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 8'h00;
        in_valid <= 1'b0;
        op <= OP_PIXEL;
        active <= 1'b0;
        sprite_layer <= 8'h00;
        x_pos <= '0;
        row_index <= '0;
        pattern_word <= '0;
        mask_word <= '0;
        attr_value <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gap_pct = 10;
        receiver_stall_pct = 73;
        foreach (directed_rows[i])
        begin
            send_job(directed_rows[i].job);
            case (directed_rows[i].kind)
                CHECK_PREDICT:
                    void'(predict_commands(directed_rows[i].job));
                CHECK_SINGLE:
                    pending_cmds.push_back('{directed_rows[i].job.op,
                                             directed_rows[i].job.row_index[7:0],
                                             directed_rows[i].typed_cell,
                                             directed_rows[i].typed_and,
                                             directed_rows[i].typed_or, 1'b1});
                default:
                    ;
            endcase
            sender_gap();
        end
        wait_drained();

        write_render_layer(8'hFF);
        run_phase(10, 73, 85, 1'b0);
        write_render_layer(8'($urandom_range(1, 254)));
        run_phase(73, 10, 85, 1'b0);
        write_render_layer(8'h00);
        run_phase(0, 0, 85, 1'b1);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
